@@ src/trlc_pkg.sv @@
package trlc_pkg;

  localparam int ALPHA = 26;
  localparam int ROTORS = 3;
  localparam int STAGES = 3 * ROTORS;

  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5a;

  localparam logic [1:0] OP_CIPHER = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_POS    = 2'd2;

  localparam logic [2:0] TS_LEFT   = 3'd0;
  localparam logic [2:0] TS_MIDDLE = 3'd1;
  localparam logic [2:0] TS_RIGHT  = 3'd2;
  localparam logic [2:0] TS_REFL   = 3'd3;
  localparam logic [2:0] TS_PLUG   = 3'd4;

  localparam logic [2:0] CFG_RING_L  = 3'd0;
  localparam logic [2:0] CFG_RING_M  = 3'd1;
  localparam logic [2:0] CFG_RING_R  = 3'd2;
  localparam logic [2:0] CFG_NOTCH_M = 3'd3;
  localparam logic [2:0] CFG_NOTCH_R = 3'd4;

  typedef struct packed {
    logic       v;
    logic [1:0] op;
    logic [2:0] sel;
    logic [4:0] idx;
    logic [4:0] val;
    logic [7:0] ch;
    logic       ltr;
    logic [4:0] sl;
    logic [4:0] sm;
    logic [4:0] sr;
    logic       pv;
    logic [4:0] pa;
  } stage_t;

  function automatic logic [4:0] add26(logic [4:0] a, logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(ALPHA)) s = s - 6'(ALPHA);
    return s[4:0];
  endfunction

  function automatic logic [4:0] sub26(logic [4:0] a, logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + 6'(ALPHA) - {1'b0, b};
    if (s >= 6'(ALPHA)) s = s - 6'(ALPHA);
    return s[4:0];
  endfunction

  function automatic logic [4:0] wrap26(logic [4:0] a);
    return (a >= 5'(ALPHA)) ? a - 5'(ALPHA) : a;
  endfunction

endpackage

@@ src/trlc_ram.sv @@
module trlc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ src/three_rotor_letter_cipher.sv @@
// Three-rotor letter cipher, stream in and stream out.
// in_* carries one command word per handshake: encipher a byte, write one
// entry of a rotor, reflector or plugboard table, or set a rotor position.
// Every word yields exactly one result word on out_*.
// The path is a nine-step pipeline, one table RAM per lookup (plugboard,
// three rotors forward, reflector, three rotors inverse, plugboard). Table
// writes travel down the same pipeline and land in each RAM at its own step,
// so commands take effect in order with no hazard.
// Throughput: one word per cycle while out_tready is high; set by the single read port of each RAM.
// Rotor stepping is done as a word is accepted.
// cfg_* writes ring settings and notches; write only while idle.
// Reset clears positions, configuration and the pipeline; the plugboard
// reads as identity until written, other tables are undefined until written.
// While a result word waits with out_tready low the whole pipeline holds and
// in_tready drops.
module three_rotor_letter_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], table_select[4:2], entry_index[9:5], entry_value[14:10],
  // char_in[22:15]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // char_out[7:0], was_enciphered[8]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import trlc_pkg::*;

  logic [4:0] ring_l_r, ring_m_r, ring_r_r, notch_m_r, notch_r_r;
  logic [4:0] pos_r [ROTORS];
  logic [4:0] pos_nxt [ROTORS];
  logic [ALPHA-1:0] pval0_r, pval8_r;
  stage_t st_r [STAGES];
  stage_t info [STAGES];
  logic en, acc;

  logic       ram_we [STAGES];
  logic [4:0] ram_wa [STAGES];
  logic [4:0] ram_wd [STAGES];
  logic [4:0] ram_ra [STAGES];
  logic [4:0] ram_rd [STAGES];

  logic [1:0] i_op;
  logic [2:0] i_sel;
  logic [4:0] i_idx, i_val, i_ltr_idx;
  logic [7:0] i_ch;
  logic       i_is_lc, i_is_uc, i_ltr;
  logic       mid_notch, right_notch;
  logic [4:0] d0, d8;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign acc = in_tvalid && en;

  assign i_op  = in_tdata[1:0];
  assign i_sel = in_tdata[4:2];
  assign i_idx = in_tdata[9:5];
  assign i_val = in_tdata[14:10];
  assign i_ch  = in_tdata[22:15];
  assign i_is_lc = (i_ch >= CH_LA) && (i_ch <= CH_LZ);
  assign i_is_uc = (i_ch >= CH_UA) && (i_ch <= CH_UZ);
  assign i_ltr = (i_op == OP_CIPHER) && (i_is_lc || i_is_uc);
  assign i_ltr_idx = i_is_lc ? 5'(i_ch - CH_LA) : 5'(i_ch - CH_UA);

  assign mid_notch = pos_r[1] == notch_m_r;
  assign right_notch = pos_r[2] == notch_r_r;

  always_comb begin
    for (int r = 0; r < ROTORS; r++) pos_nxt[r] = pos_r[r];
    if (i_ltr) begin
      if (mid_notch) pos_nxt[0] = add26(pos_r[0], 5'd1);
      if (mid_notch || right_notch) pos_nxt[1] = add26(pos_r[1], 5'd1);
      pos_nxt[2] = add26(pos_r[2], 5'd1);
    end else if (i_op == OP_POS && i_sel < 3'(ROTORS) && i_idx < 5'(ALPHA)) begin
      pos_nxt[i_sel[1:0]] = i_idx;
    end
  end

  always_comb begin
    info[0].v   = acc;
    info[0].op  = i_op;
    info[0].sel = i_sel;
    info[0].idx = i_idx;
    info[0].val = i_val;
    info[0].ch  = i_ch;
    info[0].ltr = i_ltr;
    info[0].sl  = sub26(pos_nxt[0], wrap26(ring_l_r));
    info[0].sm  = sub26(pos_nxt[1], wrap26(ring_m_r));
    info[0].sr  = sub26(pos_nxt[2], wrap26(ring_r_r));
    info[0].pv  = pval0_r[i_ltr_idx];
    info[0].pa  = i_ltr_idx;
    for (int k = 1; k < STAGES; k++) info[k] = st_r[k-1];
    info[STAGES-1].pv = pval8_r[ram_ra[STAGES-1]];
    info[STAGES-1].pa = ram_ra[STAGES-1];
  end

  assign d0 = st_r[0].pv ? ram_rd[0] : st_r[0].pa;

  always_comb begin
    ram_ra[0] = i_ltr_idx;
    ram_ra[1] = add26(d0, st_r[0].sr);
    ram_ra[2] = add26(sub26(ram_rd[1], st_r[1].sr), st_r[1].sm);
    ram_ra[3] = add26(sub26(ram_rd[2], st_r[2].sm), st_r[2].sl);
    ram_ra[4] = sub26(ram_rd[3], st_r[3].sl);
    ram_ra[5] = add26(ram_rd[4], st_r[4].sl);
    ram_ra[6] = add26(sub26(ram_rd[5], st_r[5].sl), st_r[5].sm);
    ram_ra[7] = add26(sub26(ram_rd[6], st_r[6].sm), st_r[6].sr);
    ram_ra[8] = sub26(ram_rd[7], st_r[7].sr);
  end

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      logic ok;
      logic [2:0] want;
      logic inv;
      ok = info[k].v && en && info[k].op == OP_WRITE &&
           info[k].idx < 5'(ALPHA) && info[k].val < 5'(ALPHA);
      inv = 1'b0;
      case (k)
        1: want = TS_RIGHT;
        2: want = TS_MIDDLE;
        3: want = TS_LEFT;
        4: want = TS_REFL;
        5: begin want = TS_LEFT; inv = 1'b1; end
        6: begin want = TS_MIDDLE; inv = 1'b1; end
        7: begin want = TS_RIGHT; inv = 1'b1; end
        default: want = TS_PLUG;
      endcase
      ram_we[k] = ok && info[k].sel == want;
      ram_wa[k] = inv ? info[k].val : info[k].idx;
      ram_wd[k] = inv ? info[k].idx : info[k].val;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_ram
    trlc_ram #(.WIDTH(5), .DEPTH(ALPHA)) u_ram (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (ram_wa[k]),
      .wdata (ram_wd[k]),
      .re    (en),
      .raddr (ram_ra[k]),
      .rdata (ram_rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) st_r[k].v <= 1'b0;
      for (int r = 0; r < ROTORS; r++) pos_r[r] <= '0;
      pval0_r <= '0;
      pval8_r <= '0;
      ring_l_r <= '0;
      ring_m_r <= '0;
      ring_r_r <= '0;
      notch_m_r <= '0;
      notch_r_r <= '0;
    end else begin
      if (en) begin
        for (int k = 0; k < STAGES; k++) st_r[k] <= info[k];
      end
      if (acc) begin
        for (int r = 0; r < ROTORS; r++) pos_r[r] <= pos_nxt[r];
      end
      if (ram_we[0]) pval0_r[ram_wa[0]] <= 1'b1;
      if (ram_we[STAGES-1]) pval8_r[ram_wa[STAGES-1]] <= 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RING_L:  ring_l_r <= cfg_wdata;
          CFG_RING_M:  ring_m_r <= cfg_wdata;
          CFG_RING_R:  ring_r_r <= cfg_wdata;
          CFG_NOTCH_M: notch_m_r <= cfg_wdata;
          CFG_NOTCH_R: notch_r_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign d8 = st_r[STAGES-1].pv ? ram_rd[STAGES-1] : st_r[STAGES-1].pa;

  always_comb begin
    out_tdata = '0;
    if (st_r[STAGES-1].ltr) begin
      out_tdata[7:0] = CH_LA + {3'd0, d8};
      out_tdata[8] = 1'b1;
    end else if (st_r[STAGES-1].op == OP_CIPHER) begin
      out_tdata[7:0] = st_r[STAGES-1].ch;
    end
  end

  assign out_tvalid = st_r[STAGES-1].v;

endmodule

@@ src/trlc_checker.sv @@
module trlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:0] >= 8'h61 && out_tdata[7:0] <= 8'h7a)
    else $error("enciphered word not a lowercase letter");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

endmodule

bind three_rotor_letter_cipher trlc_checker u_trlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/three_rotor_letter_cipher_test.sv @@
`timescale 1ns / 1ps

module three_rotor_letter_cipher_test;
  import trlc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PER_PHASE = 250;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [4:0]  cfg_wdata;

  three_rotor_letter_cipher dut (.*);

  // shadow state of the cipher
  logic [4:0] fwd_map [3][26];
  logic [4:0] inv_map [3][26];
  logic [4:0] refl_map [26];
  logic [4:0] plug_map [26];
  logic [4:0] rotor_pos [3];
  logic [4:0] ring_set [3];
  logic [4:0] notch_mid, notch_rgt;

  typedef struct {
    logic        typed;
    logic [15:0] word;
  } expect_t;

  expect_t     pending_words [$];
  logic        row_typed;
  logic [15:0] row_word;
  bit          quiet;
  bit          held;
  int          errors, rx_count, cycles;
  int          n_letters, n_other, n_cmds;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int rotor_pass(int r, int s, bit inverse);
    int shift, ix, m;
    shift = (rotor_pos[r] + 26 - (ring_set[r] % 26)) % 26;
    ix = (s + shift) % 26;
    m = inverse ? inv_map[r][ix] : fwd_map[r][ix];
    return ((m % 26) + 26 - shift) % 26;
  endfunction

  function automatic logic [15:0] cipher_word(logic [23:0] w);
    logic [1:0] op;
    logic [2:0] sel;
    logic [4:0] ix, vl;
    logic [7:0] ch;
    int s;
    bit mid_hit, rgt_hit;
    op = w[1:0];
    sel = w[4:2];
    ix = w[9:5];
    vl = w[14:10];
    ch = w[22:15];
    case (op)
      OP_CIPHER: begin
        if (ch >= CH_LA && ch <= CH_LZ) s = ch - CH_LA;
        else if (ch >= CH_UA && ch <= CH_UZ) s = ch - CH_UA;
        else begin
          n_other++;
          return {8'h00, ch};
        end
        n_letters++;
        mid_hit = rotor_pos[1] == notch_mid;
        rgt_hit = rotor_pos[2] == notch_rgt;
        if (mid_hit) rotor_pos[0] = 5'((rotor_pos[0] + 1) % 26);
        if (mid_hit || rgt_hit) rotor_pos[1] = 5'((rotor_pos[1] + 1) % 26);
        rotor_pos[2] = 5'((rotor_pos[2] + 1) % 26);
        s = plug_map[s] % 26;
        for (int r = 2; r >= 0; r--) s = rotor_pass(r, s, 0);
        s = refl_map[s] % 26;
        for (int r = 0; r < 3; r++) s = rotor_pass(r, s, 1);
        s = plug_map[s] % 26;
        return {7'd0, 1'b1, 8'(CH_LA + s)};
      end
      OP_WRITE: begin
        n_cmds++;
        if (ix < 26 && vl < 26) begin
          if (sel <= TS_RIGHT) begin
            fwd_map[sel][ix] = vl;
            inv_map[sel][vl] = ix;
          end else if (sel == TS_REFL) refl_map[ix] = vl;
          else if (sel == TS_PLUG) plug_map[ix] = vl;
        end
      end
      OP_POS: begin
        n_cmds++;
        if (sel <= TS_RIGHT && ix < 26) rotor_pos[sel] = ix;
      end
      default: n_cmds++;
    endcase
    return 16'd0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words outstanding", $realtime, pending_words.size());
      $display("** three_rotor_letter_cipher: FAILED **");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      expect_t e;
      e.word = cipher_word(in_tdata);
      e.typed = row_typed;
      if (row_typed) e.word = row_word;
      pending_words.insert(pending_words.size(), e);
    end
    if (rst_n && out_tvalid && out_tready) begin
      rx_count++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $realtime, out_tdata);
      end else begin
        expect_t e;
        e = pending_words.pop_front();
        if (out_tdata[7:0] !== e.word[7:0] || out_tdata[8] !== e.word[8]
            || out_tdata[15:9] !== 7'd0) begin
          errors++;
          $display("%0t: mismatch, expected %h, got %h", $realtime, e.word, out_tdata);
        end
      end
    end
  end

  // receiver
  initial begin
    int stall;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (rx_count >= 300 && !held) begin
        held = 1;
        stall = 80;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_word(logic [1:0] op, logic [2:0] sel, logic [4:0] ix, logic [4:0] vl,
                           logic [7:0] ch, logic typed = 0, logic [15:0] word = 0);
    int gap;
    @(negedge clk);
    in_tdata = {1'b0, ch, vl, ix, sel, op};
    row_typed = typed;
    row_word = word;
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 0;
      row_typed = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 0;
    row_typed = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] ix, logic [4:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = ix;
    cfg_wdata = v;
    case (ix)
      CFG_RING_L:  ring_set[0] = v;
      CFG_RING_M:  ring_set[1] = v;
      CFG_RING_R:  ring_set[2] = v;
      CFG_NOTCH_M: notch_mid = v;
      CFG_NOTCH_R: notch_rgt = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_perm(logic [2:0] sel);
    int p [26];
    int j, t;
    for (int i = 0; i < 26; i++) p[i] = i;
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    for (int i = 0; i < 26; i++)
      send_word(OP_WRITE, sel, 5'(i), 5'(p[i]), 8'($urandom), 1, 16'd0);
  endtask

  task automatic random_word;
    int k;
    k = $urandom_range(0, 99);
    if (k < 60)
      send_word(OP_CIPHER, 3'($urandom), 5'($urandom), 5'($urandom),
                ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'($urandom_range(0, 25)));
    else if (k < 70)
      send_word(OP_CIPHER, 3'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
    else if (k < 82)
      send_word(OP_WRITE, 3'($urandom_range(0, 4)), 5'($urandom_range(0, 25)),
                5'($urandom_range(0, 25)), 8'($urandom));
    else if (k < 88)
      send_word(OP_WRITE, 3'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
    else if (k < 96)
      send_word(OP_POS, 3'($urandom_range(0, 3)), 5'($urandom_range(0, 27)),
                5'($urandom), 8'($urandom));
    else
      send_word(OP_NONE, 3'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
  endtask

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  sel;
    logic [4:0]  ix;
    logic [4:0]  vl;
    logic [7:0]  ch;
    logic        typed;
    logic [15:0] word;
  } stim_row_t;

  stim_row_t stim_rows [24] = '{
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h00, 1, 16'h0000},
    '{OP_CIPHER, 3'd7, 5'd31, 5'd31, 8'hff, 1, 16'h00ff},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h40, 1, 16'h0040},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h5b, 1, 16'h005b},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h60, 1, 16'h0060},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h7b, 1, 16'h007b},
    '{OP_POS,    TS_MIDDLE, 5'd0, 5'd0, 8'h00, 1, 16'h0000},
    '{OP_POS,    TS_RIGHT,  5'd0, 5'd0, 8'h00, 1, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h61, 0, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h7a, 0, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h41, 0, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h5a, 0, 16'h0000},
    '{OP_WRITE,  TS_PLUG, 5'd0, 5'd25, 8'h00, 1, 16'h0000},
    '{OP_WRITE,  TS_PLUG, 5'd31, 5'd1, 8'h00, 1, 16'h0000},
    '{OP_WRITE,  TS_REFL, 5'd1, 5'd31, 8'h00, 1, 16'h0000},
    '{OP_WRITE,  3'd5,    5'd1, 5'd1,  8'h00, 1, 16'h0000},
    '{OP_WRITE,  3'd7,    5'd2, 5'd3,  8'h00, 1, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h61, 0, 16'h0000},
    '{OP_POS,    TS_LEFT,  5'd25, 5'd0, 8'h00, 1, 16'h0000},
    '{OP_POS,    TS_RIGHT, 5'd26, 5'd0, 8'h00, 1, 16'h0000},
    '{OP_POS,    3'd3,     5'd4,  5'd0, 8'h00, 1, 16'h0000},
    '{OP_WRITE,  TS_RIGHT, 5'd25, 5'd0, 8'h00, 1, 16'h0000},
    '{OP_CIPHER, 3'd0, 5'd0,  5'd0,  8'h5a, 0, 16'h0000},
    '{OP_NONE,   3'd7, 5'd31, 5'd31, 8'hff, 1, 16'h0000}
  };

  initial begin
    logic [4:0] settings [4][5];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    row_typed = 0;
    row_word = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    quiet = 0;
    held = 0;
    errors = 0;
    rx_count = 0;
    cycles = 0;
    n_letters = 0;
    n_other = 0;
    n_cmds = 0;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 26; i++) begin
        fwd_map[r][i] = 0;
        inv_map[r][i] = 0;
      end
      rotor_pos[r] = 0;
      ring_set[r] = 0;
    end
    for (int i = 0; i < 26; i++) begin
      refl_map[i] = 0;
      plug_map[i] = 5'(i);
    end
    notch_mid = 0;
    notch_rgt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // every rotor and reflector entry is written before the first letter
    for (int t = TS_LEFT; t <= TS_REFL; t++) load_perm(3'(t));
    foreach (stim_rows[i])
      send_word(stim_rows[i].op, stim_rows[i].sel, stim_rows[i].ix, stim_rows[i].vl,
                stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].word);

    settings = '{'{5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
                 '{5'd25, 5'd25, 5'd25, 5'd25, 5'd25},
                 '{5'd31, 5'd26, 5'd13, 5'd31, 5'd30},
                 '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0}};
    for (int k = 0; k < 5; k++) settings[3][k] = 5'($urandom_range(0, 25));
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int k = 0; k < 5; k++) set_reg(3'(k), settings[ph][k]);
      quiet = (ph == 1);
      for (int n = 0; n < RAND_PER_PHASE; n++) random_word();
    end
    quiet = 0;
    drain();

    $display("covered %0d letters, %0d pass-through bytes, %0d table and position commands",
             n_letters, n_other, n_cmds);
    $display("four ring/notch settings incl. extremes and out-of-range, one long output stall");
    if (errors == 0) begin
      $display("** three_rotor_letter_cipher: PASSED **");
    end else begin
      $display("** three_rotor_letter_cipher: FAILED **");
    end
    $finish;
  end

endmodule
